@@ hw/rtl/mfalu_pkg.sv @@
package mfalu_pkg;

   localparam logic [2:0] KIND_MUL = 3'd0;
   localparam logic [2:0] KIND_DIV = 3'd1;
   localparam logic [2:0] KIND_ADD = 3'd2;
   localparam logic [2:0] KIND_SUB = 3'd3;
   localparam logic [2:0] KIND_CMP = 3'd4;

   localparam logic [1:0] ORDER_LESS    = 2'd0;
   localparam logic [1:0] ORDER_EQUAL   = 2'd1;
   localparam logic [1:0] ORDER_GREATER = 2'd2;

   typedef enum logic [2:0] {
      MS_IMP_A = 3'd0,
      MS_IMP_B = 3'd1,
      MS_P1    = 3'd2,
      MS_P2    = 3'd3,
      MS_DEN   = 3'd4
   } mul_src_type;

   typedef enum logic [1:0] {
      DS_NUM_G   = 2'd0,
      DS_DEN_G   = 2'd1,
      DS_NUM_DEN = 2'd2
   } div_src_type;

   typedef struct packed {
      logic        load;
      logic        mul_start;
      logic        mul_save;
      mul_src_type mul_src;
      logic        combine;
      logic        gcd_init;
      logic        gcd_step;
      logic        gcd_shift;
      logic        div_start;
      logic        div_save;
      div_src_type div_src;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic mul_busy;
      logic div_busy;
      logic arith;
      logic u_zero;
      logic k_zero;
   } status_type;

endpackage

@@ hw/rtl/mfalu_mul.sv @@
module mfalu_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  op_x,
   input  logic [63:0]  op_y,
   output logic         busy,
   output logic [127:0] acc
);
   logic [63:0]  x_ff, x_in, y_ff, y_in;
   logic [63:0]  prod_ff, prod_in;
   logic [1:0]   pshift_ff, pshift_in;
   logic         pvalid_ff, pvalid_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic [127:0] acc_ff, acc_in;
   logic [31:0]  xh, yh;
   logic [127:0] pp;

   assign xh = cnt_ff[1] ? x_ff[63:32] : x_ff[31:0];
   assign yh = cnt_ff[0] ? y_ff[63:32] : y_ff[31:0];
   assign prod_in = xh * yh;
   assign pshift_in = {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};

   always_comb begin
      pp = {64'd0, prod_ff};
      case (pshift_ff)
         2'd1:    pp = {32'd0, prod_ff, 32'd0};
         2'd2:    pp = {prod_ff, 64'd0};
         default: pp = {64'd0, prod_ff};
      endcase
   end

   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      pvalid_in = 1'b0;
      if (pvalid_ff) begin
         acc_in = acc_ff + pp;
      end
      if (start) begin
         x_in    = op_x;
         y_in    = op_y;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != 3'd4) begin
            pvalid_in = 1'b1;
            cnt_in    = cnt_ff + 3'd1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      prod_ff   <= prod_in;
      pshift_ff <= pshift_in;
      acc_ff    <= acc_in;
      if (reset) begin
         busy_ff   <= 1'b0;
         pvalid_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         busy_ff   <= busy_in;
         pvalid_ff <= pvalid_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign busy = busy_ff;
   assign acc  = acc_ff;
endmodule

@@ hw/rtl/mfalu_div.sv @@
module mfalu_div (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] dividend,
   input  logic [127:0] divisor,
   output logic         busy,
   output logic [127:0] quo,
   output logic [127:0] rem
);
   logic [127:0] n_ff, n_in, d_ff, d_in, rr_ff, rr_in, q_ff, q_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic [127:0] sh;
   logic         ge;

   assign sh = {rr_ff[126:0], n_ff[127]};
   assign ge = sh >= d_ff;

   always_comb begin
      n_in    = n_ff;
      d_in    = d_ff;
      rr_in   = rr_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         n_in    = dividend;
         d_in    = divisor;
         rr_in   = '0;
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rr_in  = ge ? sh - d_ff : sh;
         q_in   = {q_ff[126:0], ge};
         n_in   = {n_ff[126:0], 1'b0};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd127) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff  <= n_in;
      d_ff  <= d_in;
      rr_ff <= rr_in;
      q_ff  <= q_in;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign busy = busy_ff;
   assign quo  = q_ff;
   assign rem  = rr_ff;
endmodule

@@ hw/rtl/mfalu_datapath.sv @@
module mfalu_datapath #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mfalu_pkg::cmd_type    cmd,
   output mfalu_pkg::status_type status,
   input  logic [2:0]           req_kind,
   input  logic [31:0]          req_a_whole,
   input  logic [31:0]          req_a_numerator,
   input  logic [30:0]          req_a_denominator,
   input  logic [31:0]          req_b_whole,
   input  logic [31:0]          req_b_numerator,
   input  logic [30:0]          req_b_denominator,
   output logic [31:0]          res_whole,
   output logic [31:0]          res_numerator,
   output logic [30:0]          res_denominator,
   output logic [1:0]           res_order,
   output logic                 res_overflow
);
   import mfalu_pkg::*;

   localparam logic [127:0] LIM = 128'(1) << (WORD_WIDTH - 1);

   logic [2:0]   kind_ff, kind_in;
   logic [31:0]  aw_ff, aw_in, anum_ff, anum_in, bw_ff, bw_in, bnum_ff, bnum_in;
   logic [30:0]  ad_ff, ad_in, bd_ff, bd_in;
   logic         an_ff, an_in, bn_ff, bn_in;
   logic [63:0]  am_ff, am_in, bm_ff, bm_in;
   logic         p1n_ff, p1n_in, p2n_ff, p2n_in;
   logic [127:0] p1m_ff, p1m_in, p2m_ff, p2m_in;
   logic         nneg_ff, nneg_in;
   logic [127:0] nmag_ff, nmag_in, den_ff, den_in;
   logic [1:0]   order_ff, order_in;
   logic [127:0] u_ff, u_in, v_ff, v_in;
   logic [6:0]   k_ff, k_in;
   logic [127:0] quo_ff, quo_in, rem_ff, rem_in;
   logic [31:0]  rw_ff, rw_in, rn_ff, rn_in;
   logic [30:0]  rd_ff, rd_in;
   logic [1:0]   ro_ff, ro_in;
   logic         rv_ff, rv_in;

   logic [63:0]  mul_x, mul_y;
   logic         mul_busy;
   logic [127:0] mul_acc;
   logic [127:0] div_n, div_d, div_q, div_r;
   logic         div_busy;
   logic         arith;

   logic [31:0]  fw, fnum;
   logic [64:0]  pv, sum65, mag65;

   assign arith = (kind_ff == KIND_MUL) || (kind_ff == KIND_DIV) ||
                  (kind_ff == KIND_ADD) || (kind_ff == KIND_SUB);

   function automatic logic [31:0] mag32(input logic [31:0] w);
      mag32 = w[31] ? (~w + 32'd1) : w;
   endfunction

   always_comb begin
      mul_x = '0;
      mul_y = '0;
      case (cmd.mul_src)
         MS_IMP_A: begin
            mul_x = {32'd0, mag32(aw_ff)};
            mul_y = {33'd0, ad_ff};
         end
         MS_IMP_B: begin
            mul_x = {32'd0, mag32(bw_ff)};
            mul_y = {33'd0, bd_ff};
         end
         MS_P1: begin
            mul_x = am_ff;
            mul_y = (kind_ff == KIND_MUL) ? bm_ff : {33'd0, bd_ff};
         end
         MS_P2: begin
            mul_x = bm_ff;
            mul_y = {33'd0, ad_ff};
         end
         MS_DEN: begin
            mul_x = {33'd0, ad_ff};
            mul_y = (kind_ff == KIND_DIV) ? bm_ff : {33'd0, bd_ff};
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   mfalu_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .op_x  (mul_x),
      .op_y  (mul_y),
      .busy  (mul_busy),
      .acc   (mul_acc)
   );

   always_comb begin
      div_n = nmag_ff;
      div_d = v_ff;
      case (cmd.div_src)
         DS_NUM_G: begin
            div_n = nmag_ff;
            div_d = v_ff;
         end
         DS_DEN_G: begin
            div_n = den_ff;
            div_d = v_ff;
         end
         DS_NUM_DEN: begin
            div_n = nmag_ff;
            div_d = den_ff;
         end
         default: begin
            div_n = nmag_ff;
            div_d = den_ff;
         end
      endcase
   end

   mfalu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .busy     (div_busy),
      .quo      (div_q),
      .rem      (div_r)
   );

   // improper numerator: sign(w)*|w|*d + num
   always_comb begin
      fw    = (cmd.mul_src == MS_IMP_B) ? bw_ff : aw_ff;
      fnum  = (cmd.mul_src == MS_IMP_B) ? bnum_ff : anum_ff;
      pv    = {1'b0, mul_acc[63:0]};
      if (fw[31]) begin
         pv = ~pv + 65'd1;
      end
      sum65 = pv + {{33{fnum[31]}}, fnum};
      mag65 = sum65[64] ? (~sum65 + 65'd1) : sum65;
   end

   always_comb begin
      kind_in  = kind_ff;
      aw_in    = aw_ff;
      anum_in  = anum_ff;
      ad_in    = ad_ff;
      bw_in    = bw_ff;
      bnum_in  = bnum_ff;
      bd_in    = bd_ff;
      an_in    = an_ff;
      am_in    = am_ff;
      bn_in    = bn_ff;
      bm_in    = bm_ff;
      p1n_in   = p1n_ff;
      p1m_in   = p1m_ff;
      p2n_in   = p2n_ff;
      p2m_in   = p2m_ff;
      nneg_in  = nneg_ff;
      nmag_in  = nmag_ff;
      den_in   = den_ff;
      order_in = order_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      k_in     = k_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      rw_in    = rw_ff;
      rn_in    = rn_ff;
      rd_in    = rd_ff;
      ro_in    = ro_ff;
      rv_in    = rv_ff;

      if (cmd.load) begin
         kind_in = req_kind;
         aw_in   = req_a_whole;
         anum_in = req_a_numerator;
         ad_in   = (req_a_denominator == '0) ? 31'd1 : req_a_denominator;
         bw_in   = req_b_whole;
         bnum_in = req_b_numerator;
         bd_in   = (req_b_denominator == '0) ? 31'd1 : req_b_denominator;
      end

      if (cmd.mul_save) begin
         case (cmd.mul_src)
            MS_IMP_A: begin
               an_in = sum65[64];
               am_in = mag65[63:0];
            end
            MS_IMP_B: begin
               bn_in = sum65[64];
               bm_in = mag65[63:0];
            end
            MS_P1: begin
               p1m_in = mul_acc;
               p1n_in = ((kind_ff == KIND_MUL) || (kind_ff == KIND_DIV)) ?
                        (an_ff ^ bn_ff) : an_ff;
               if (mul_acc == '0) begin
                  p1n_in = 1'b0;
               end
            end
            MS_P2: begin
               p2m_in = mul_acc;
               p2n_in = (kind_ff == KIND_SUB) ? !bn_ff : bn_ff;
               if (mul_acc == '0) begin
                  p2n_in = 1'b0;
               end
            end
            MS_DEN: begin
               den_in = mul_acc;
            end
            default: begin
               den_in = den_ff;
            end
         endcase
      end

      if (cmd.combine) begin
         nneg_in = p1n_ff;
         nmag_in = p1m_ff;
         if (kind_ff == KIND_DIV && den_ff == '0) begin
            den_in  = 128'd1;
            nneg_in = an_ff && (p1m_ff != '0);
         end
         if (kind_ff == KIND_ADD || kind_ff == KIND_SUB) begin
            if (p1n_ff == p2n_ff) begin
               nmag_in = p1m_ff + p2m_ff;
               nneg_in = p1n_ff;
            end else if (p1m_ff >= p2m_ff) begin
               nmag_in = p1m_ff - p2m_ff;
               nneg_in = p1n_ff;
            end else begin
               nmag_in = p2m_ff - p1m_ff;
               nneg_in = p2n_ff;
            end
            if (nmag_in == '0) begin
               nneg_in = 1'b0;
            end
         end
         if (p1n_ff != p2n_ff) begin
            order_in = p1n_ff ? ORDER_LESS : ORDER_GREATER;
         end else if (p1m_ff == p2m_ff) begin
            order_in = ORDER_EQUAL;
         end else if ((p1m_ff < p2m_ff) != p1n_ff) begin
            order_in = ORDER_LESS;
         end else begin
            order_in = ORDER_GREATER;
         end
      end

      if (cmd.gcd_init) begin
         u_in = nmag_ff;
         v_in = den_ff;
         k_in = '0;
      end
      if (cmd.gcd_step) begin
         if (!u_ff[0] && !v_ff[0]) begin
            u_in = u_ff >> 1;
            v_in = v_ff >> 1;
            k_in = k_ff + 7'd1;
         end else if (!u_ff[0]) begin
            u_in = u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_in = v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_in = u_ff - v_ff;
         end else begin
            v_in = v_ff - u_ff;
         end
      end
      if (cmd.gcd_shift) begin
         v_in = v_ff << 1;
         k_in = k_ff - 7'd1;
      end

      if (cmd.div_save) begin
         case (cmd.div_src)
            DS_NUM_G:   nmag_in = div_q;
            DS_DEN_G:   den_in  = div_q;
            DS_NUM_DEN: begin
               quo_in = div_q;
               rem_in = div_r;
            end
            default:    quo_in  = div_q;
         endcase
      end

      if (cmd.out_load) begin
         rw_in = '0;
         rn_in = '0;
         rd_in = 31'd1;
         ro_in = ORDER_LESS;
         rv_in = 1'b0;
         if (arith) begin
            rw_in = nneg_ff ? (~quo_ff[31:0] + 32'd1) : quo_ff[31:0];
            rn_in = nneg_ff ? (~rem_ff[31:0] + 32'd1) : rem_ff[31:0];
            rd_in = den_ff[30:0];
            rv_in = (quo_ff > LIM) || (quo_ff == LIM && !nneg_ff) ||
                    (den_ff > LIM - 128'd1);
         end else if (kind_ff == KIND_CMP) begin
            ro_in = order_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      aw_ff    <= aw_in;
      anum_ff  <= anum_in;
      ad_ff    <= ad_in;
      bw_ff    <= bw_in;
      bnum_ff  <= bnum_in;
      bd_ff    <= bd_in;
      an_ff    <= an_in;
      am_ff    <= am_in;
      bn_ff    <= bn_in;
      bm_ff    <= bm_in;
      p1n_ff   <= p1n_in;
      p1m_ff   <= p1m_in;
      p2n_ff   <= p2n_in;
      p2m_ff   <= p2m_in;
      nneg_ff  <= nneg_in;
      nmag_ff  <= nmag_in;
      den_ff   <= den_in;
      order_ff <= order_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      k_ff     <= k_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      rw_ff    <= rw_in;
      rn_ff    <= rn_in;
      rd_ff    <= rd_in;
      ro_ff    <= ro_in;
      rv_ff    <= rv_in;
   end

   assign status.mul_busy = mul_busy;
   assign status.div_busy = div_busy;
   assign status.arith    = arith;
   assign status.u_zero   = (u_ff == '0);
   assign status.k_zero   = (k_ff == '0);

   assign res_whole       = rw_ff;
   assign res_numerator   = rn_ff;
   assign res_denominator = rd_ff;
   assign res_order       = ro_ff;
   assign res_overflow    = rv_ff;
endmodule

@@ hw/rtl/mfalu_ctrl.sv @@
module mfalu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  mfalu_pkg::status_type status,
   output mfalu_pkg::cmd_type    cmd
);
   import mfalu_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b000000000001,
      ST_IMP_GO    = 12'b000000000010,
      ST_IMP_WAIT  = 12'b000000000100,
      ST_PRD_GO    = 12'b000000001000,
      ST_PRD_WAIT  = 12'b000000010000,
      ST_COMBINE   = 12'b000000100000,
      ST_GCD_INIT  = 12'b000001000000,
      ST_GCD_RUN   = 12'b000010000000,
      ST_GCD_SHIFT = 12'b000100000000,
      ST_DIV_GO    = 12'b001000000000,
      ST_DIV_WAIT  = 12'b010000000000,
      ST_FINISH    = 12'b100000000000
   } state_type;

   state_type   state_ff, state_in;
   mul_src_type msrc_ff, msrc_in;
   div_src_type dsrc_ff, dsrc_in;
   logic        rvalid_ff, rvalid_in;
   logic        out_free;

   assign out_free  = !rvalid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      msrc_in  = msrc_ff;
      dsrc_in  = dsrc_ff;
      cmd      = '0;
      cmd.mul_src = msrc_ff;
      cmd.div_src = dsrc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               msrc_in  = MS_IMP_A;
               state_in = ST_IMP_GO;
            end
         end
         ST_IMP_GO: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_IMP_WAIT;
         end
         ST_IMP_WAIT: begin
            if (!status.mul_busy) begin
               cmd.mul_save = 1'b1;
               if (msrc_ff == MS_IMP_A) begin
                  msrc_in  = MS_IMP_B;
                  state_in = ST_IMP_GO;
               end else begin
                  msrc_in  = MS_P1;
                  state_in = ST_PRD_GO;
               end
            end
         end
         ST_PRD_GO: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_PRD_WAIT;
         end
         ST_PRD_WAIT: begin
            if (!status.mul_busy) begin
               cmd.mul_save = 1'b1;
               case (msrc_ff)
                  MS_P1: begin
                     msrc_in  = MS_P2;
                     state_in = ST_PRD_GO;
                  end
                  MS_P2: begin
                     msrc_in  = MS_DEN;
                     state_in = ST_PRD_GO;
                  end
                  default: state_in = ST_COMBINE;
               endcase
            end
         end
         ST_COMBINE: begin
            cmd.combine = 1'b1;
            state_in    = status.arith ? ST_GCD_INIT : ST_FINISH;
         end
         ST_GCD_INIT: begin
            cmd.gcd_init = 1'b1;
            state_in     = ST_GCD_RUN;
         end
         ST_GCD_RUN: begin
            if (status.u_zero) begin
               state_in = ST_GCD_SHIFT;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_GCD_SHIFT: begin
            // restore the common power of two
            if (status.k_zero) begin
               dsrc_in  = DS_NUM_G;
               state_in = ST_DIV_GO;
            end else begin
               cmd.gcd_shift = 1'b1;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!status.div_busy) begin
               cmd.div_save = 1'b1;
               case (dsrc_ff)
                  DS_NUM_G: begin
                     dsrc_in  = DS_DEN_G;
                     state_in = ST_DIV_GO;
                  end
                  DS_DEN_G: begin
                     dsrc_in  = DS_NUM_DEN;
                     state_in = ST_DIV_GO;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_FINISH: begin
            // hold until the output word is free
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rvalid_in = rvalid_ff;
      if (rvalid_ff && !rsp_stall) begin
         rvalid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         msrc_ff   <= MS_IMP_A;
         dsrc_ff   <= DS_NUM_G;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         msrc_ff   <= msrc_in;
         dsrc_ff   <= dsrc_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign rsp_valid = rvalid_ff;

`ifndef SYNTHESIS
   a_mul_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> !status.mul_busy) else $error("multiplier restarted while busy");
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy) else $error("divider restarted while busy");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rvalid_ff || !rsp_stall)) else $error("pending result overwritten");
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rvalid_ff) else $error("loaded result not presented");
`endif
endmodule

@@ hw/rtl/mixed_fraction_alu_unit.sv @@
// Compare and unused kinds run the five products and the combine step before rsp_valid; arithmetic
// kinds add the binary GCD loop, its shift-back and the divisions.
// Cost is set by the shared 32x32 multiplier (five 64x64 products)
// and the 128-bit radix-2 divider (three divisions).
// Throughput: one word at a time; the next word is taken the cycle after the result loads.
// Reset is synchronous, active high, and clears the controller and handshake state.
module mixed_fraction_alu_unit #(
   parameter int WORD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic signed [31:0] req_a_whole,
   input  logic signed [31:0] req_a_numerator,
   input  logic [30:0] req_a_denominator,
   input  logic signed [31:0] req_b_whole,
   input  logic signed [31:0] req_b_numerator,
   input  logic [30:0] req_b_denominator,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_res_whole,
   output logic signed [31:0] rsp_res_numerator,
   output logic [30:0] rsp_res_denominator,
   output logic [1:0]  rsp_order,
   output logic        rsp_overflow
);
   import mfalu_pkg::*;

   cmd_type    cmd;
   status_type status;

   mfalu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mfalu_datapath #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_a_whole       (req_a_whole),
      .req_a_numerator   (req_a_numerator),
      .req_a_denominator (req_a_denominator),
      .req_b_whole       (req_b_whole),
      .req_b_numerator   (req_b_numerator),
      .req_b_denominator (req_b_denominator),
      .res_whole         (rsp_res_whole),
      .res_numerator     (rsp_res_numerator),
      .res_denominator   (rsp_res_denominator),
      .res_order         (rsp_order),
      .res_overflow      (rsp_overflow)
   );
endmodule

@@ tb/tb_mixed_fraction_alu_unit.sv @@
module tb_mixed_fraction_alu_unit;
   import mfalu_pkg::*;

   typedef struct {
      logic signed [31:0] whole;
      logic signed [31:0] numerator;
      logic [30:0]        denominator;
      logic [1:0]         order;
      logic               overflow;
   } fraction_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_kind;
   logic signed [31:0] req_a_whole;
   logic signed [31:0] req_a_numerator;
   logic [30:0] req_a_denominator;
   logic signed [31:0] req_b_whole;
   logic signed [31:0] req_b_numerator;
   logic [30:0] req_b_denominator;
   logic        rsp_valid;
   logic        rsp_stall;
   logic signed [31:0] rsp_res_whole;
   logic signed [31:0] rsp_res_numerator;
   logic [30:0] rsp_res_denominator;
   logic [1:0]  rsp_order;
   logic        rsp_overflow;

   fraction_result_type pending_results[$];
   int unsigned      mismatch_count;
   int unsigned      send_idle_pct;
   int unsigned      stall_pct;
   int unsigned      hold_cycles;
   bit               timed_out;

   mixed_fraction_alu_unit #(.WORD_WIDTH(32)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_a_whole(req_a_whole), .req_a_numerator(req_a_numerator),
      .req_a_denominator(req_a_denominator),
      .req_b_whole(req_b_whole), .req_b_numerator(req_b_numerator),
      .req_b_denominator(req_b_denominator),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_res_whole(rsp_res_whole), .rsp_res_numerator(rsp_res_numerator),
      .rsp_res_denominator(rsp_res_denominator), .rsp_order(rsp_order),
      .rsp_overflow(rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // exact rational arithmetic on 128-bit values
   function automatic fraction_result_type fraction_compute(
         logic [2:0] kind,
         logic signed [31:0] aw, logic signed [31:0] an, logic [30:0] adr,
         logic signed [31:0] bw, logic signed [31:0] bn, logic [30:0] bdr);
      fraction_result_type res;
      logic signed [127:0] ad, bd, a_imp, b_imp, num, den, lhs, rhs, tmp;
      logic signed [127:0] wa, na, wb, nb;
      logic [127:0] mag, dmag, x, y, g, q, r;
      logic neg;
      res.whole = '0;
      res.numerator = '0;
      res.denominator = 31'd1;
      res.order = ORDER_LESS;
      res.overflow = 1'b0;
      ad = (adr == 0) ? 128'sd1 : {97'd0, adr};
      bd = (bdr == 0) ? 128'sd1 : {97'd0, bdr};
      wa = aw; na = an; wb = bw; nb = bn;
      a_imp = wa * ad + na;
      b_imp = wb * bd + nb;
      if (kind == KIND_CMP) begin
         lhs = a_imp * bd;
         rhs = b_imp * ad;
         res.order = (lhs < rhs) ? ORDER_LESS : (lhs == rhs) ? ORDER_EQUAL : ORDER_GREATER;
         return res;
      end
      case (kind)
         KIND_MUL: begin
            num = a_imp * b_imp;
            den = ad * bd;
         end
         KIND_DIV: begin
            num = a_imp * bd;
            if (b_imp < 0) num = -num;
            tmp = (b_imp < 0) ? -b_imp : b_imp;
            den = ad * tmp;
            // divisor of zero: force denominator to one, keep sign of a
            if (den == 0) begin
               num = a_imp * bd;
               den = 128'sd1;
            end
         end
         KIND_ADD: begin
            num = a_imp * bd + b_imp * ad;
            den = ad * bd;
         end
         KIND_SUB: begin
            num = a_imp * bd - b_imp * ad;
            den = ad * bd;
         end
         default: return res;
      endcase
      neg = num < 0;
      mag = neg ? -num : num;
      dmag = den;
      x = mag;
      y = dmag;
      while (y != 0) begin
         g = x % y;
         x = y;
         y = g;
      end
      g = x;
      mag = mag / g;
      dmag = dmag / g;
      q = mag / dmag;
      r = mag % dmag;
      res.overflow = (q > 128'h8000_0000) || (q == 128'h8000_0000 && !neg)
                     || (dmag > 128'h7FFF_FFFF);
      res.whole = neg ? -q[31:0] : q[31:0];
      res.numerator = neg ? -r[31:0] : r[31:0];
      res.denominator = dmag[30:0];
      return res;
   endfunction

   // receiver stall, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      fraction_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result word: whole %0d num %0d den %0d",
                        rsp_res_whole, rsp_res_numerator, rsp_res_denominator);
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_res_whole !== exp_res.whole || rsp_res_numerator !== exp_res.numerator
                || rsp_res_denominator !== exp_res.denominator
                || rsp_order !== exp_res.order || rsp_overflow !== exp_res.overflow) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp %0d %0d/%0d ord %0d ovf %0d, got %0d %0d/%0d ord %0d ovf %0d",
                           exp_res.whole, exp_res.numerator, exp_res.denominator,
                           exp_res.order, exp_res.overflow, rsp_res_whole,
                           rsp_res_numerator, rsp_res_denominator, rsp_order,
                           rsp_overflow);
            end
         end
      end
   end

   task automatic send_word(logic [2:0] kind,
         logic signed [31:0] aw, logic signed [31:0] an, logic [30:0] ad,
         logic signed [31:0] bw, logic signed [31:0] bn, logic [30:0] bd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_a_whole <= aw; req_a_numerator <= an; req_a_denominator <= ad;
      req_b_whole <= bw; req_b_numerator <= bn; req_b_denominator <= bd;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(fraction_compute(kind, aw, an, ad, bw, bn, bd));
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_signed();
      case ($urandom_range(5))
         0: return $urandom_range(40) - 20;
         1: return $urandom_range(2000) - 1000;
         2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         3: return $urandom_range(200000) - 100000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] pick_denominator();
      case ($urandom_range(5))
         0: return 31'd0;
         1: return 31'($urandom_range(1, 12));
         2: return 31'($urandom_range(1, 1000));
         3: return 31'h7FFF_FFFF;
         4: return 31'($urandom_range(1, 100000));
         default: return 31'($urandom);
      endcase
   endfunction

   task automatic send_random_words(int count);
      for (int i = 0; i < count; i++)
         send_word(3'($urandom_range(7)), pick_signed(), pick_signed(), pick_denominator(),
                   pick_signed(), pick_signed(), pick_denominator());
   endtask

   task automatic test_directed();
      send_idle_pct = 0; stall_pct = 0;
      send_word(KIND_MUL, 1, 1, 2, 2, 1, 3);
      send_word(KIND_DIV, 1, 1, 2, 2, 1, 3);
      send_word(KIND_ADD, 1, 1, 2, 2, 1, 3);
      send_word(KIND_SUB, 1, 1, 2, 2, 1, 3);
      send_word(KIND_CMP, 1, 1, 2, 2, 1, 3);
      send_word(KIND_CMP, 2, 1, 3, 1, 1, 2);
      send_word(KIND_CMP, 1, 2, 4, 1, 1, 2);
      // zero denominators count as one
      send_word(KIND_ADD, 3, 5, 0, -2, 7, 0);
      // divide by zero value
      send_word(KIND_DIV, 5, 3, 4, 0, 0, 7);
      send_word(KIND_DIV, -5, 3, 4, 1, -3, 3);
      // whole-number result
      send_word(KIND_MUL, 0, 3, 4, 0, 4, 3);
      send_word(KIND_SUB, 2, 1, 2, 2, 1, 2);
      // extremes and overflow
      send_word(KIND_MUL, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF,
                32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF);
      send_word(KIND_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFE);
      send_word(KIND_DIV, 32'sh7FFF_FFFF, 0, 1, 0, 1, 31'h7FFF_FFFF);
      send_word(KIND_SUB, 32'sh8000_0000, 0, 1, 0, 0, 1);
      send_word(KIND_MUL, 32'sh8000_0000, 0, 1, 1, 0, 1);
      send_word(KIND_MUL, 32'sh8000_0000, 0, 1, -1, 0, 1);
      send_word(KIND_CMP, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
      send_word(KIND_ADD, -1, 1, 3, 0, -1, 6);
      send_word(3'd5, 1, 2, 3, 4, 5, 6);
      send_word(3'd6, -1, -2, 0, -4, -5, 0);
      send_word(3'd7, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 0, 0, 0);
      drop_valid();
   endtask

   task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_p, int count);
      send_idle_pct = idle_pct; stall_pct = stall_p;
      send_random_words(count);
      drop_valid();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0; stall_pct = 0;
      @(posedge clock);
      hold_cycles <= 3000;
      send_random_words(6);
      drop_valid();
      // pause until the unit has drained
      wait (pending_results.size() == 0);
      @(posedge clock);
      send_random_words(20);
      drop_valid();
   endtask

   initial begin
      #(4 * 8_000_000);
      timed_out = 1'b1;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      mismatch_count = 0; timed_out = 1'b0; hold_cycles = 0;
      send_idle_pct = 0; stall_pct = 0;
      reset = 1'b1; rsp_stall = 1'b0; req_valid = 1'b0; req_kind = KIND_MUL;
      req_a_whole = '0; req_a_numerator = '0; req_a_denominator = '0;
      req_b_whole = '0; req_b_numerator = '0; req_b_denominator = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(0, 0, 300);
      test_random_phase(51, 0, 230);
      test_random_phase(0, 51, 230);
      test_random_phase(9, 9, 230);
      test_backpressure();
      test_random_phase(0, 0, 200);
      wait (pending_results.size() == 0);
      repeat (800) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

@@ sim.f @@
hw/rtl/mfalu_pkg.sv
hw/rtl/mfalu_mul.sv
hw/rtl/mfalu_div.sv
hw/rtl/mfalu_datapath.sv
hw/rtl/mfalu_ctrl.sv
hw/rtl/mixed_fraction_alu_unit.sv
tb/tb_mixed_fraction_alu_unit.sv
